>>> hw/rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scan package
// Shared constants, types and register codes for the pattern scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

	// Number of pattern bytes held in the pattern registers.
	localparam int unsigned PAT_BYTES = 32;

	// Default window depth of the scan unit.
	localparam int unsigned PATTERN_MAX_DEF = 32;

	// Address space width used when forming the match address.
	localparam int unsigned ADDR_WIDTH = 32;
	localparam logic [31:0] ADDR_MASK =
		(ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

	// Configuration port geometry.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned PLEN_W     = 6;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_WORD_0 = 3'd0,
		CFG_PATTERN_WORD_1 = 3'd1,
		CFG_PATTERN_WORD_2 = 3'd2,
		CFG_PATTERN_WORD_3 = 3'd3,
		CFG_WILDCARD_MASK  = 3'd4,
		CFG_PATTERN_LENGTH = 3'd5,
		CFG_BASE_ADDRESS   = 3'd6
	} cfg_idx_t;

	// Pattern bytes, byte j in bits 8j+7 down to 8j.
	typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

endpackage

`default_nettype wire

>>> hw/rtl/mbps_window_cmp.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scan window compare
// Byte shift window and a parallel masked compare against the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_window_cmp #(
	parameter int unsigned PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 shift_en,
	input  wire logic [7:0]           data_in,
	input  wire mbps_pkg::pat_bytes_t pattern,
	input  wire logic [mbps_pkg::PAT_BYTES-1:0] wild,
	input  wire logic [LEN_W-1:0]     len,
	output logic                      hit
);

	import mbps_pkg::*;

	localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	// Entry 0 holds the newest byte.
	logic [PATTERN_MAX-1:0][7:0] win_q;
	logic [PATTERN_MAX-1:0]      pos_ok;

	// Shift the window by one byte for every accepted transaction.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q[0] <= data_in;
			for (int k = 1; k < PATTERN_MAX; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	// Pattern byte j lines up with the window entry len-1-j. Positions past the
	// pattern length always pass; positions past the pattern registers read as
	// a zero byte with no wildcard.
	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pos
		logic [IDX_W-1:0] idx;
		logic             in_use;
		assign idx    = IDX_W'(len - LEN_W'(1) - LEN_W'(j));
		assign in_use = (len > LEN_W'(j));
		if (j < PAT_BYTES) begin : g_cfg
			assign pos_ok[j] = !in_use || wild[j] || (pattern[j] == win_q[idx]);
		end else begin : g_zero
			assign pos_ok[j] = !in_use || (win_q[idx] == 8'h00);
		end
	end

	assign hit = &pos_ok;

endmodule

`default_nettype wire

>>> hw/rtl/masked_byte_pattern_scan_unit.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scan unit
// Scans a byte stream for a pattern with per-byte wildcards and reports the
// first match address and the number of matches for each region.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one byte of the scanned region per transaction,
// with last_byte marking the region's final byte. Each byte is accepted when
// in_valid is high and in_stall is low. One result transaction leaves on the
// output channel for every region. The unit takes one byte every cycle while
// in_stall is low: the window shift and the parallel masked compare sit between
// the input register and the result register. While a result waits under
// out_stall, bytes of the next region still flow in; in_stall rises only when
// another region end meets a full output register. Configuration registers are
// written through cfg_write, cfg_index and cfg_data; the user must do so only
// while no region is in progress, which the unit leaves unchecked. Reset clears
// the scan state and sets the registers to defaults, with pattern length one.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scan_unit #(
	parameter int unsigned PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration port
	input  wire logic                            cfg_write,
	input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            last_byte,
	// Output channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 match_found,
	output logic [31:0]                          first_match_address,
	output logic [31:0]                          match_count
);

	import mbps_pkg::*;

	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

	// Configuration registers
	logic [CFG_DATA_W-1:0] pat_word_q [4];
	logic [31:0]           wild_q;
	logic [PLEN_W-1:0]     plen_q;
	logic [31:0]           base_q;

	// Input stage and offset counter
	logic [31:0]      off_q;
	logic             valid_s1;
	logic             last_s1;
	logic             full_s1;
	logic [31:0]      start_s1;

	// Region accumulators
	logic             seen_q;
	logic [31:0]      first_q;
	logic [31:0]      cnt_q;

	// Result register
	logic             out_valid_q;
	logic             found_q;
	logic [31:0]      addr_q;
	logic [31:0]      count_q;

	logic [LEN_W-1:0] len_eff;
	logic [31:0]      len_m1;
	pat_bytes_t       pat_bytes;
	logic             cmp_hit;
	logic             hit;
	logic             in_acc;
	logic             s1_adv;
	logic             new_seen;
	logic [31:0]      new_first;
	logic [31:0]      new_cnt;
	logic [31:0]      addr_sum;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < 4; w++) begin
				pat_word_q[w] <= '0;
			end
			wild_q <= '0;
			plen_q <= PLEN_W'(1);
			base_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PATTERN_WORD_0: pat_word_q[0] <= cfg_data;
				CFG_PATTERN_WORD_1: pat_word_q[1] <= cfg_data;
				CFG_PATTERN_WORD_2: pat_word_q[2] <= cfg_data;
				CFG_PATTERN_WORD_3: pat_word_q[3] <= cfg_data;
				CFG_WILDCARD_MASK:  wild_q        <= cfg_data[31:0];
				CFG_PATTERN_LENGTH: plen_q        <= cfg_data[PLEN_W-1:0];
				CFG_BASE_ADDRESS:   base_q        <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign pat_bytes = {pat_word_q[3], pat_word_q[2], pat_word_q[1], pat_word_q[0]};

	// Effective pattern length, clamped to the range one to the window depth.
	always_comb begin
		if (plen_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(plen_q) > 32'(PATTERN_MAX)) begin
			len_eff = LEN_W'(PATTERN_MAX);
		end else begin
			len_eff = LEN_W'(plen_q);
		end
	end

	assign len_m1 = 32'(len_eff) - 32'd1;

	// Handshake. A byte that ends no region always moves on; a region end
	// waits only while the previous result is still held.
	assign s1_adv   = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	// Input stage: byte offset, window fill check and match start offset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			off_q    <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				if (last_byte) begin
					off_q <= '0;
				end else if (off_q != 32'hFFFF_FFFF) begin
					off_q <= off_q + 32'd1;
				end
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_s1  <= last_byte;
			full_s1  <= (off_q >= len_m1);
			start_s1 <= off_q - len_m1;
		end
	end

	// Window and masked compare, shifted in step with the input stage.
	mbps_window_cmp #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_cmp (
		.clk     (clk),
		.shift_en(in_acc),
		.data_in (data_byte),
		.pattern (pat_bytes),
		.wild    (wild_q),
		.len     (len_eff),
		.hit     (cmp_hit)
	);

	assign hit = full_s1 && cmp_hit;

	// Accumulator update for the byte leaving the input stage.
	always_comb begin
		new_seen  = seen_q || hit;
		new_first = seen_q ? first_q : start_s1;
		new_cnt   = (hit && (cnt_q != 32'hFFFF_FFFF)) ? cnt_q + 32'd1 : cnt_q;
		addr_sum  = (base_q + new_first) & ADDR_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			first_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				if (last_s1) begin
					seen_q  <= 1'b0;
					first_q <= '0;
					cnt_q   <= '0;
				end else begin
					seen_q  <= new_seen;
					first_q <= new_first;
					cnt_q   <= new_cnt;
				end
			end
			if (s1_adv && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register, loaded at the end of each region.
	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			found_q <= new_seen;
			addr_q  <= new_seen ? addr_sum : '0;
			count_q <= new_cnt;
		end
	end

	assign out_valid           = out_valid_q;
	assign match_found         = found_q;
	assign first_match_address = addr_q;
	assign match_count         = count_q;

endmodule

`default_nettype wire
